[design/ctd_pkg.sv]
// Shared types and constants for the chunked transfer decoder.
// No dependencies; used by ctd_step and chunked_transfer_decoder.

package ctd_pkg;

    // Sizing of the decoder
    localparam int MAX_HEX_DIGITS = 16;
    localparam int LENGTH_WIDTH   = 32;
    localparam int CHUNK_W        = 64;
    localparam int LINE_W         = 16;
    localparam int HEXCNT_W       = 5;
    localparam int COUNT_W        = 32;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = (LENGTH_WIDTH >= 32) ? 32'hFFFF_FFFF
        : COUNT_W'((64'd1 << LENGTH_WIDTH) - 64'd1);
    localparam logic [LINE_W-1:0] LINE_SAT = {LINE_W{1'b1}};
    localparam logic [LINE_W-1:0] MAX_LINE_RESET = 16'd4096;

    // Special characters
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Parser phase
    typedef enum logic [2:0] {
        PH_DIGITS  = 3'd0,
        PH_EXT     = 3'd1,
        PH_SIZE_LF = 3'd2,
        PH_DATA    = 3'd3,
        PH_DATA_CR = 3'd4,
        PH_DATA_LF = 3'd5,
        PH_TRAILER = 3'd6
    } phase_t;

    // Body status codes
    typedef enum logic [1:0] {
        ST_RUN   = 2'd0,
        ST_DONE  = 2'd1,
        ST_BAD   = 2'd2,
        ST_SHORT = 2'd3
    } status_t;

    // Decoder state carried from byte to byte
    typedef struct packed {
        phase_t                phase;
        logic [CHUNK_W-1:0]    chunk_rem;
        logic [LINE_W-1:0]     line_pos;
        logic [HEXCNT_W-1:0]   hex_cnt;
        logic [1:0]            trl_bytes;
        logic                  prev_cr;
        logic [COUNT_W-1:0]    consumed;
        status_t               fstat;
    } state_t;

    // One result item
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        status_t     status;
        logic [31:0] raw_length;
    } result_t;

    localparam state_t STATE_CLEAR = '{
        phase:     PH_DIGITS,
        chunk_rem: '0,
        line_pos:  '0,
        hex_cnt:   '0,
        trl_bytes: '0,
        prev_cr:   1'b0,
        consumed:  '0,
        fstat:     ST_RUN
    };

endpackage

[design/ctd_step.sv]
// Per-byte next-state and result logic of the chunked transfer decoder.
// Depends on ctd_pkg; purely combinational, sits between input and result registers.

module ctd_step (
    input  ctd_pkg::state_t        cur,
    input  logic [7:0]             data_byte,
    input  logic                   first_byte,
    input  logic                   last_byte,
    input  logic [15:0]            max_size_line,
    output ctd_pkg::state_t        nxt,
    output ctd_pkg::result_t       res
);

    // hex character decode: {valid, value}
    function automatic logic [4:0] hex_of(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
        else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
        else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
        return r;
    endfunction

    ctd_pkg::state_t s;
    logic [4:0]                       hex;
    logic                             pay;
    logic [ctd_pkg::LINE_W-1:0]       line_bump;
    logic                             tail_bad;
    ctd_pkg::phase_t                  tail_phase;

    always_comb
    begin
        // a new body clears everything before this byte
        s   = first_byte ? ctd_pkg::STATE_CLEAR : cur;
        nxt = s;
        pay = 1'b0;
        hex = hex_of(data_byte);

        line_bump  = (s.line_pos != ctd_pkg::LINE_SAT) ? s.line_pos + 1'b1 : s.line_pos;
        tail_bad   = (s.line_pos >= max_size_line) || (data_byte == ctd_pkg::CHAR_LF);
        tail_phase = (data_byte == ctd_pkg::CHAR_CR) ? ctd_pkg::PH_SIZE_LF : ctd_pkg::PH_EXT;

        if (s.fstat == ctd_pkg::ST_RUN)
        begin
            if (s.consumed < ctd_pkg::COUNT_LIMIT)
            begin
                nxt.consumed = s.consumed + 1'b1;
            end

            case (s.phase)
                ctd_pkg::PH_DIGITS:
                begin
                    if (hex[4])
                    begin
                        nxt.hex_cnt = s.hex_cnt + 1'b1;
                        if (32'(s.hex_cnt) + 32'd1 > 32'(ctd_pkg::MAX_HEX_DIGITS))
                        begin
                            nxt.fstat = ctd_pkg::ST_BAD;
                        end
                        else
                        begin
                            nxt.chunk_rem = {s.chunk_rem[ctd_pkg::CHUNK_W-5:0], hex[3:0]};
                            nxt.line_pos  = line_bump;
                        end
                    end
                    else if (s.hex_cnt == '0)
                    begin
                        nxt.fstat = ctd_pkg::ST_BAD;
                    end
                    else
                    begin
                        if (tail_bad) nxt.fstat = ctd_pkg::ST_BAD;
                        else          nxt.phase = tail_phase;
                        nxt.line_pos = line_bump;
                    end
                end
                ctd_pkg::PH_EXT:
                begin
                    if (tail_bad) nxt.fstat = ctd_pkg::ST_BAD;
                    else          nxt.phase = tail_phase;
                    nxt.line_pos = line_bump;
                end
                ctd_pkg::PH_SIZE_LF:
                begin
                    if (data_byte != ctd_pkg::CHAR_LF)
                    begin
                        nxt.fstat = ctd_pkg::ST_BAD;
                    end
                    else
                    begin
                        nxt.line_pos  = '0;
                        nxt.hex_cnt   = '0;
                        nxt.phase     = (s.chunk_rem == '0) ? ctd_pkg::PH_TRAILER
                                                            : ctd_pkg::PH_DATA;
                        nxt.trl_bytes = '0;
                        nxt.prev_cr   = 1'b0;
                    end
                end
                ctd_pkg::PH_DATA:
                begin
                    nxt.chunk_rem = s.chunk_rem - 1'b1;
                    if (s.chunk_rem == ctd_pkg::CHUNK_W'(1)) nxt.phase = ctd_pkg::PH_DATA_CR;
                    pay = 1'b1;
                end
                ctd_pkg::PH_DATA_CR:
                begin
                    if (data_byte != ctd_pkg::CHAR_CR) nxt.fstat = ctd_pkg::ST_BAD;
                    else                               nxt.phase = ctd_pkg::PH_DATA_LF;
                end
                ctd_pkg::PH_DATA_LF:
                begin
                    if (data_byte != ctd_pkg::CHAR_LF) nxt.fstat = ctd_pkg::ST_BAD;
                    else                               nxt.phase = ctd_pkg::PH_DIGITS;
                end
                default:
                begin
                    // trailer: only LF ends a line and it must follow CR
                    if (data_byte == ctd_pkg::CHAR_LF)
                    begin
                        if (s.trl_bytes == 2'd0 || !s.prev_cr) nxt.fstat = ctd_pkg::ST_BAD;
                        else if (s.trl_bytes == 2'd1)          nxt.fstat = ctd_pkg::ST_DONE;
                        nxt.trl_bytes = '0;
                        nxt.prev_cr   = 1'b0;
                    end
                    else
                    begin
                        if (s.trl_bytes != 2'd3) nxt.trl_bytes = s.trl_bytes + 1'b1;
                        nxt.prev_cr = (data_byte == ctd_pkg::CHAR_CR);
                    end
                end
            endcase

            if (nxt.fstat == ctd_pkg::ST_RUN && last_byte)
            begin
                nxt.fstat = ctd_pkg::ST_SHORT;
            end
        end

        // result item
        res.payload_byte  = pay ? data_byte : 8'd0;
        res.payload_valid = pay;
        res.status        = nxt.fstat;
        res.raw_length    = (nxt.fstat == ctd_pkg::ST_DONE) ? 32'(nxt.consumed) : 32'd0;
    end

endmodule

[design/chunked_transfer_decoder.sv]
// Top level of the chunked transfer decoder: input register, state, result register.
// Depends on ctd_pkg and ctd_step.
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------------------------
//   in       | in_valid/in_ready   | data_byte, first_byte, last_byte
//   out      | out_valid/out_ready | payload_byte, payload_valid, status, raw_length
//   cfg      | cfg_valid/cfg_ready | max_size_line
//
// One byte per cycle sustained while out_ready is high; a byte passes the input register, then the result register.
// The state update for a byte is a single pass through ctd_step while it moves to the result.
// A stalled result holds the result register; the input register takes one more byte only if it was empty.
// Reset clears all decoder state and sets max_size_line to 4096; cfg_ready is always high.

module chunked_transfer_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  payload_byte,
    output logic        payload_valid,
    output logic [1:0]  status,
    output logic [31:0] raw_length,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] max_size_line
);

    logic               in_valid_reg;
    logic [7:0]         byte_reg;
    logic               first_reg;
    logic               last_reg;
    logic               out_valid_reg;
    logic [15:0]        max_line_reg;
    logic               advance;
    ctd_pkg::state_t    state_reg;
    ctd_pkg::state_t    state_next;
    ctd_pkg::result_t   res_reg;
    ctd_pkg::result_t   res_next;

    // pipeline control
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_line_reg <= ctd_pkg::MAX_LINE_RESET;
        end
        else if (cfg_valid)
        begin
            max_line_reg <= max_size_line;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg  <= data_byte;
            first_reg <= first_byte;
            last_reg  <= last_byte;
        end
    end

    // per-byte decode
    ctd_step u_step (
        .cur           (state_reg),
        .data_byte     (byte_reg),
        .first_byte    (first_reg),
        .last_byte     (last_reg),
        .max_size_line (max_line_reg),
        .nxt           (state_next),
        .res           (res_next)
    );

    // decoder state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ctd_pkg::STATE_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign payload_byte  = res_reg.payload_byte;
    assign payload_valid = res_reg.payload_valid;
    assign status        = res_reg.status;
    assign raw_length    = res_reg.raw_length;

    // raw length only reported on completion
    a_len_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && raw_length != 32'd0 |-> status == ctd_pkg::ST_DONE)
        else $error("raw_length set without completion");

    // non-payload results carry a zero byte
    a_pay_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !payload_valid |-> payload_byte == 8'd0)
        else $error("payload_byte nonzero without payload_valid");

    // digit count never runs past one over the limit
    a_hex_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(state_reg.hex_cnt) <= 32'(ctd_pkg::MAX_HEX_DIGITS) + 32'd1)
        else $error("hex digit count out of range");

    // state only moves when a byte goes through
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("decoder state changed without a byte");

endmodule
